@@ hw/rtl/mbss_pkg.sv @@
// ----------------------------------------------------------------------------
// mbss_pkg: shared types and constants for the masked byte signature scan
// request structs, configuration register codes, cell control bundle
// ----------------------------------------------------------------------------
package mbss_pkg;

	localparam int unsigned PATTERN_MAX_DEF = 16;
	localparam int unsigned SIG_BYTES       = 16;
	localparam int unsigned ADDR_W          = 32;
	localparam int unsigned LEN_W           = 5;
	localparam int unsigned MASK_W          = 16;
	localparam int unsigned CFG_DATA_W      = 64;
	localparam int unsigned CFG_IDX_W       = 3;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_ADDRESS = 3'd0,
		REG_PATTERN_LOW  = 3'd1,
		REG_PATTERN_HIGH = 3'd2,
		REG_CARE_MASK    = 3'd3,
		REG_PATTERN_LEN  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_req_t;

	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] match_address;
	} out_req_t;

	// control that every cell in the chain sees
	typedef struct packed {
		logic       adv;
		logic       clr;
		logic [7:0] data_byte;
	} cell_ctl_t;

endpackage

@@ hw/rtl/mbss_cell.sv @@
// ----------------------------------------------------------------------------
// mbss_cell: one signature position of the scan chain
// holds the partial-match bit for the pattern prefix ending at this position
// ----------------------------------------------------------------------------
module mbss_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  mbss_pkg::cell_ctl_t ctl,
	input  logic [7:0]         sig,
	input  logic               care,
	input  logic               prev_q,
	output logic               hit_nx,
	output logic               part_q
);

	// prefix up to the previous position matched one byte ago, and this byte fits
	assign hit_nx = prev_q & (~care | (ctl.data_byte == sig));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q <= 1'b0;
		end else if (ctl.adv) begin
			part_q <= ctl.clr ? 1'b0 : hit_nx;
		end
	end

endmodule

@@ hw/rtl/masked_byte_signature_scan_top.sv @@
// ----------------------------------------------------------------------------
// masked_byte_signature_scan_top: wildcard byte signature search
// streams a memory region one byte per request and reports the first match
// ----------------------------------------------------------------------------
// Takes one region byte per clock cycle, back to back, for as long as the
// result register is free or being drained; a stall on the result side only
// holds the input once a finished result waits and cannot leave. The search
// is a chain of PATTERN_MAX cells: cell k keeps a bit saying that the pattern
// bytes 0..k matched the bytes ending one request ago, so each new byte costs
// one compare per cell and a pick of the cell at pattern_len - 1. Wildcard
// positions (care bit clear) always match. The first match of a region is
// kept; the request that carries last_byte produces one result request in the
// next cycle with found and base_address plus the match offset (mod 2^32), or
// found = 0 and address 0. An empty pattern or one longer than PATTERN_MAX
// never matches. After the result the chain and the counters clear, so the
// next region can follow in the very next cycle. The user writes configuration
// (cfg_wr_en / cfg_index / cfg_data) only while the block is idle, unenforced.
// ----------------------------------------------------------------------------
module masked_byte_signature_scan_top #(
	parameter int unsigned PATTERN_MAX = mbss_pkg::PATTERN_MAX_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_wr_en,
	input  logic [mbss_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mbss_pkg::CFG_DATA_W-1:0]     cfg_data,
	// region byte requests
	input  logic                                in_valid,
	output logic                                in_stall,
	input  mbss_pkg::in_req_t                   in_req,
	// result requests
	output logic                                out_valid,
	input  logic                                out_stall,
	output mbss_pkg::out_req_t                  out_req
);

	localparam int unsigned AW = mbss_pkg::ADDR_W;
	localparam int unsigned LW = mbss_pkg::LEN_W;

	// configuration registers
	logic [AW-1:0]                       base_address_q;
	logic [8*mbss_pkg::SIG_BYTES-1:0]    pattern_q;
	logic [mbss_pkg::MASK_W-1:0]         care_mask_q;
	logic [LW-1:0]                       pattern_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_address_q <= '0;
			pattern_q      <= '0;
			care_mask_q    <= '0;
			pattern_len_q  <= '0;
		end else if (cfg_wr_en) begin
			unique case (mbss_pkg::cfg_reg_t'(cfg_index))
				mbss_pkg::REG_BASE_ADDRESS: base_address_q <= cfg_data[AW-1:0];
				mbss_pkg::REG_PATTERN_LOW:  pattern_q[63:0] <= cfg_data;
				mbss_pkg::REG_PATTERN_HIGH: pattern_q[127:64] <= cfg_data;
				mbss_pkg::REG_CARE_MASK:    care_mask_q <= cfg_data[mbss_pkg::MASK_W-1:0];
				mbss_pkg::REG_PATTERN_LEN:  pattern_len_q <= cfg_data[LW-1:0];
				default: ;
			endcase
		end
	end

	// handshake: hold input only while a finished result is stuck
	logic out_valid_q;
	logic in_acc;

	assign in_stall = out_valid_q & out_stall;
	assign in_acc   = in_valid & ~in_stall;

	// cell chain
	mbss_pkg::cell_ctl_t   ctl;
	logic [PATTERN_MAX-1:0] hit_nx;
	logic [PATTERN_MAX-1:0] part_q;

	assign ctl.adv       = in_acc;
	assign ctl.clr       = in_req.last_byte;
	assign ctl.data_byte = in_req.data_byte;

	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
		logic prev;
		if (k == 0) begin : g_head
			// empty prefix always matches
			assign prev = 1'b1;
		end else begin : g_link
			assign prev = part_q[k-1];
		end
		mbss_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.sig    (pattern_q[8*k +: 8]),
			.care   (care_mask_q[k]),
			.prev_q (prev),
			.hit_nx (hit_nx[k]),
			.part_q (part_q[k])
		);
	end

	// region bookkeeping
	logic [AW-1:0] region_offset_q;
	logic          match_seen_q;
	logic [AW-1:0] match_offset_q;

	logic [AW-1:0] count;
	logic          count_ok;
	logic          sel_hit;
	logic          hit;
	logic          found_nx;
	logic [AW-1:0] offset_nx;

	assign count = region_offset_q + AW'(1);
	// count >= pattern_len, only the low bits can fall short
	assign count_ok = (|count[AW-1:LW]) || (count[LW-1:0] >= pattern_len_q);

	// pick the cell at pattern_len - 1; lengths out of range select nothing
	always_comb begin
		sel_hit = 1'b0;
		for (int k = 0; k < PATTERN_MAX; k++) begin
			if (pattern_len_q == LW'(k + 1)) begin
				sel_hit = hit_nx[k];
			end
		end
	end

	assign hit       = ~match_seen_q & sel_hit & count_ok;
	assign found_nx  = match_seen_q | hit;
	assign offset_nx = hit ? (count - AW'(pattern_len_q)) : match_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_offset_q <= '0;
			match_seen_q    <= 1'b0;
			match_offset_q  <= '0;
		end else if (in_acc) begin
			if (in_req.last_byte) begin
				// region closed, start the next one clean
				region_offset_q <= '0;
				match_seen_q    <= 1'b0;
				match_offset_q  <= '0;
			end else begin
				region_offset_q <= count;
				match_seen_q    <= found_nx;
				match_offset_q  <= offset_nx;
			end
		end
	end

	// result register
	mbss_pkg::out_req_t out_req_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc && in_req.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && in_req.last_byte) begin
			out_req_q.found         <= found_nx;
			out_req_q.match_address <= found_nx ? (base_address_q + offset_nx) : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_req   = out_req_q;

	// checks
	a_result_follows_last: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && in_req.last_byte) |=> out_valid)
		else $error("no result after last byte of region");

	a_result_needs_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall && in_req.last_byte))
		else $error("result without a closing byte");

	a_no_match_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_req.found) |-> (out_req.match_address == '0))
		else $error("nonzero address on a miss");

	a_seen_needs_length: assert property (@(posedge clk) disable iff (!arst_n)
		match_seen_q |-> (pattern_len_q != '0))
		else $error("match recorded with empty pattern");

endmodule

@@ bench/mbss_result_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mbss_result_checker: scoreboard for the masked byte signature scan
// follows config writes and accepted region bytes, predicts each region's
// result and compares it field by field with what the block hands out
// ----------------------------------------------------------------------------
module mbss_result_checker
	import mbss_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  in_req_t               in_req,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  out_req_t              out_req,
	output logic                  busy,
	output int                    mismatch_count
);

	localparam int unsigned WINDOW = PATTERN_MAX_DEF;

	// register copies
	logic [ADDR_W-1:0]    sig_base;
	logic [8*SIG_BYTES-1:0] sig_bytes;
	logic [MASK_W-1:0]    sig_care;
	logic [LEN_W-1:0]     sig_len;

	// region state
	logic [7:0]  recent [WINDOW];
	logic [31:0] bytes_taken;
	logic        hit_seen;
	logic [31:0] hit_offset;

	out_req_t expected_results [$];

	task automatic clear_region();
		for (int j = 0; j < WINDOW; j++)
			recent[j] = 8'h00;
		bytes_taken = '0;
		hit_seen = 1'b0;
		hit_offset = '0;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		case (idx)
			REG_BASE_ADDRESS: sig_base = value[ADDR_W-1:0];
			REG_PATTERN_LOW:  sig_bytes[63:0] = value;
			REG_PATTERN_HIGH: sig_bytes[127:64] = value;
			REG_CARE_MASK:    sig_care = value[MASK_W-1:0];
			REG_PATTERN_LEN:  sig_len = value[LEN_W-1:0];
			default: ;
		endcase
	endtask

	// shift the byte in, look for the first match, emit on the last byte
	task automatic scan_byte(input in_req_t req);
		logic [31:0] count;
		int unsigned len;
		logic        hit;
		out_req_t    res;
		for (int j = WINDOW - 1; j > 0; j--)
			recent[j] = recent[j-1];
		recent[0] = req.data_byte;
		count = bytes_taken + 32'd1;
		len = sig_len;
		if (!hit_seen && len > 0 && len <= WINDOW && count >= len) begin
			hit = 1'b1;
			for (int k = 0; k < len; k++)
				if (sig_care[k] && recent[len-1-k] != sig_bytes[8*k +: 8])
					hit = 1'b0;
			if (hit) begin
				hit_seen = 1'b1;
				hit_offset = count - len;
			end
		end
		bytes_taken = count;
		if (req.last_byte) begin
			res.found = hit_seen;
			res.match_address = hit_seen ? sig_base + hit_offset : '0;
			expected_results.push_back(res);
			clear_region();
		end
	endtask

	task automatic check_result(input out_req_t got);
		out_req_t want;
		if (expected_results.size() == 0) begin
			$error("unexpected result: found %0d match_address %h", got.found,
				got.match_address);
			mismatch_count++;
		end else begin
			want = expected_results.pop_front();
			if (got.found !== want.found) begin
				$error("found: expected %0d, got %0d", want.found, got.found);
				mismatch_count++;
			end
			if (got.match_address !== want.match_address) begin
				$error("match_address: expected %h, got %h", want.match_address,
					got.match_address);
				mismatch_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_base = '0;
			sig_bytes = '0;
			sig_care = '0;
			sig_len = '0;
			clear_region();
			expected_results.delete();
			mismatch_count = 0;
			busy <= 1'b0;
		end else begin
			if (cfg_wr_en)
				write_reg(cfg_index, cfg_data);
			if (out_valid && !out_stall)
				check_result(out_req);
			if (in_valid && !in_stall)
				scan_byte(in_req);
			busy <= expected_results.size() != 0;
		end
	end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: masked byte signature scan
// directed regions for wildcards, empty pattern, short region, region
// boundary and address wrap, then random configurations with regions that
// carry planted and nearly planted signatures, under bursty input and
// random result stalls; a side checker predicts and compares every result
// ----------------------------------------------------------------------------
module testbench;
	import mbss_pkg::*;

	// index that no register answers to, written once to see it is ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
	localparam int RANDOM_ITEMS = 1400;

	typedef struct {
		logic [ADDR_W-1:0]      base;
		logic [8*SIG_BYTES-1:0] signature;
		logic [MASK_W-1:0]      care;
		logic [LEN_W-1:0]       len;
	} scan_cfg_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_req_t               in_req = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_req_t              out_req;
	logic                  busy;
	int                    mismatch_count;

	// stimulus bookkeeping
	scan_cfg_t   cur;
	logic [7:0]  region_q [$];
	int          burst_left = 0;
	int          items_sent = 0;
	int          hold_ask = 0;

	always #5 clk = ~clk;

	masked_byte_signature_scan_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_req    (in_req),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_req   (out_req)
	);

	mbss_result_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_req         (in_req),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_req        (out_req),
		.busy           (busy),
		.mismatch_count (mismatch_count)
	);

	function automatic logic [7:0] sig_at(input int k);
		return cur.signature[8*k +: 8];
	endfunction

	// write enable stays high across back to back writes, caller lowers it
	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	// narrow registers get junk above their width, the block must drop it
	task automatic apply_config(input scan_cfg_t c, input logic junk, input logic poke_spare);
		logic [CFG_DATA_W-1:0] pad;
		pad = junk ? {$urandom, $urandom} : '0;
		cur = c;
		put_reg(REG_BASE_ADDRESS, {pad[63:32], c.base});
		put_reg(REG_PATTERN_LOW, c.signature[63:0]);
		put_reg(REG_PATTERN_HIGH, c.signature[127:64]);
		put_reg(REG_CARE_MASK, {pad[63:16], c.care});
		put_reg(REG_PATTERN_LEN, {pad[63:5], c.len});
		if (poke_spare)
			put_reg(REG_SPARE, {$urandom, $urandom});
		cfg_wr_en <= 1'b0;
	endtask

	// sender works in bursts; a gap between bursts drops valid
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_req <= {b, last};
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// whole region from region_q, last byte flagged on the final entry
	task automatic send_region_q();
		for (int i = 0; i < region_q.size(); i++)
			send_byte(region_q[i], i == region_q.size() - 1);
		region_q.delete();
	endtask

	// hold off until every result is back, then add some slack before going on
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (busy);
		repeat (4) @(posedge clk);
		burst_left = 0;
	endtask

	// half plain noise, half signature bytes so that partial matches abound
	function automatic logic [7:0] noise_byte();
		if ($urandom_range(0, 1) == 0)
			return 8'($urandom_range(0, 255));
		return sig_at($urandom_range(0, SIG_BYTES - 1));
	endfunction

	// region of n bytes with a number of planted signatures, some of them broken
	task automatic send_region(input int n, input int plants);
		int plen;
		int at;
		int k;
		plen = cur.len;
		for (int i = 0; i < n; i++)
			region_q.push_back(noise_byte());
		if (plen >= 1 && plen <= PATTERN_MAX_DEF && n >= plen) begin
			repeat (plants) begin
				at = $urandom_range(0, n - plen);
				for (int j = 0; j < plen; j++)
					region_q[at+j] = cur.care[j] ? sig_at(j) : 8'($urandom);
				// near miss: flip one bit of one position
				if ($urandom_range(0, 3) == 0) begin
					k = $urandom_range(0, plen - 1);
					region_q[at+k] ^= 8'(1 << $urandom_range(0, 7));
				end
			end
		end
		send_region_q();
	endtask

	function automatic scan_cfg_t random_config();
		scan_cfg_t c;
		int pick;
		c.signature = {$urandom, $urandom, $urandom, $urandom};
		pick = $urandom_range(0, 19);
		if (pick < 2)
			c.len = '0;
		else if (pick < 5)
			c.len = LEN_W'($urandom_range(PATTERN_MAX_DEF + 1, 31));
		else if (pick < 7)
			c.len = LEN_W'(PATTERN_MAX_DEF);
		else if (pick < 8)
			c.len = LEN_W'(1);
		else
			c.len = LEN_W'($urandom_range(1, PATTERN_MAX_DEF));
		pick = $urandom_range(0, 9);
		case (pick)
			0: c.care = '0;
			1, 2, 3: c.care = '1;
			4: c.care = MASK_W'($urandom) & MASK_W'($urandom);
			default: c.care = MASK_W'($urandom);
		endcase
		pick = $urandom_range(0, 5);
		case (pick)
			0: c.base = '0;
			1: c.base = '1;
			2: c.base = 32'hFFFF_FFFF - $urandom_range(0, 40);
			default: c.base = $urandom;
		endcase
		return c;
	endfunction

	// result side: stall pattern changes by episode; a long hold when asked
	initial begin : receiver
		int hold_seen;
		int mode;
		int span;
		int phase;
		hold_seen = 0;
		phase = 0;
		forever begin
			if (hold_ask != hold_seen) begin
				hold_seen = hold_ask;
				out_stall <= 1'b1;
				repeat ($urandom_range(150, 300)) @(posedge clk);
			end else begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(20, 200);
				while (span > 0 && hold_ask == hold_seen) begin
					case (mode)
						0: out_stall <= 1'b0;
						1: out_stall <= ($urandom_range(0, 3) == 0);
						2: out_stall <= ($urandom_range(0, 3) != 0);
						default: out_stall <= (phase % 5) < 2;
					endcase
					phase++;
					span--;
					@(posedge clk);
				end
			end
		end
	end

	initial begin : stimulus
		scan_cfg_t c;
		int round;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// wildcard at position 2, match one byte in, base + 1 wraps to zero
		c.base = 32'hFFFF_FFFF;
		c.signature = {64'h0, 64'h0000_0000_FF00_3CA5};
		c.care = 16'b1011;
		c.len = LEN_W'(4);
		apply_config(c, 1'b0, 1'b1);
		region_q = '{8'h00, 8'hA5, 8'h3C, 8'h77, 8'hFF, 8'hA5};
		send_region_q();
		// tail of the last region plus this one would match: must not
		region_q = '{8'h3C, 8'h12, 8'hFF};
		send_region_q();
		wait_idle();

		// empty pattern never matches, even with every position a wildcard
		c.len = '0;
		c.care = '0;
		apply_config(c, 1'b0, 1'b0);
		region_q = '{8'h00, 8'hFF};
		send_region_q();
		wait_idle();

		// single byte pattern on a single byte region, base at zero
		c.base = '0;
		c.signature = {64'h0, 64'h0000_0000_0000_00FF};
		c.care = 16'h0001;
		c.len = LEN_W'(1);
		apply_config(c, 1'b0, 1'b0);
		region_q = '{8'hFF};
		send_region_q();
		region_q = '{8'h00};
		send_region_q();
		wait_idle();

		// full width pattern of wildcards matches at offset zero
		c.base = 32'h8000_0000;
		c.signature = {$urandom, $urandom, $urandom, $urandom};
		c.care = '0;
		c.len = LEN_W'(PATTERN_MAX_DEF);
		apply_config(c, 1'b0, 1'b0);
		for (int i = 0; i < PATTERN_MAX_DEF; i++)
			region_q.push_back(i[0] ? 8'hFF : 8'h00);
		send_region_q();
		wait_idle();

		// random configurations, each with a handful of regions
		round = 0;
		while (items_sent < RANDOM_ITEMS) begin
			apply_config(random_config(), 1'b1, 1'b0);
			if (round % 5 == 2) begin
				// long receiver hold while short regions keep coming
				hold_ask = hold_ask + 1;
				repeat ($urandom_range(10, 20))
					send_region($urandom_range(1, 3), $urandom_range(0, 1));
			end else begin
				repeat ($urandom_range(3, 12)) begin
					if ($urandom_range(0, 6) == 0)
						send_region($urandom_range(41, 200), $urandom_range(0, 2));
					else
						send_region($urandom_range(1, 40), $urandom_range(0, 2));
				end
			end
			wait_idle();
			round++;
		end

		// drain: wait_idle already saw the last result leave
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && !busy)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// a hung handshake ends the run here
	initial begin : watchdog
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
